// ----- rtl/duplicate_frame_filter_core_assert.svh -----
// assertion macros for the duplicate frame filter checker
`ifndef DUPLICATE_FRAME_FILTER_CORE_ASSERT_SVH
`define DUPLICATE_FRAME_FILTER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DDF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DDF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ddf_pkg.sv -----
// constants, types and command structs of the duplicate frame filter
package ddf_pkg;

    localparam int TABLE_ROWS  = 4096;   // power of two, row is the low hash bits
    localparam int LEVELS      = 4;
    localparam int CHECK_BYTES = 64;

    localparam int WORDS   = (CHECK_BYTES + 7) / 8;
    localparam int RW      = $clog2(TABLE_ROWS);
    localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int WPW     = $clog2(WORDS + 1);
    localparam int BAW     = $clog2(TABLE_ROWS * WORDS);
    localparam int WIN_W   = 48;
    localparam int BIDX_W  = 17;

    localparam logic [29:0] NS_PER_SEC = 30'(1000 * 1000 * 1000);
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000);

    typedef struct packed {
        logic          latch;
        logic          rd;
        logic          calc;
        logic          cmp;
        logic          scan;
        logic          write;
        logic          clear;
        logic [LW-1:0] lvl;
        logic [RW-1:0] clr_row;
    } t_cmd;

    typedef struct packed {
        logic first_word;
    } t_stat;

endpackage

// ----- rtl/ddf_ram.sv -----
// generic simple dual-port ram with registered read
module ddf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ddf_ctrl.sv -----
// sequencer: clearing pass, per-word read/timestamp/compare/scan/write steps
module ddf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ddf_pkg::t_stat i_stat,
    output ddf_pkg::t_cmd  o_cmd,
    output logic           o_busy
);
    import ddf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_NOW, S_CMP, S_SCAN, S_WRITE
    } t_state;

    t_state        r_state;
    logic [LW-1:0] r_lvl;
    logic [RW-1:0] r_clr_row;
    logic          r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_lvl     <= '0;
            r_clr_row <= '0;
            r_busy    <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + 1'b1;
                    if (r_clr_row == RW'(TABLE_ROWS - 1)) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_READ;
                        r_busy  <= 1'b1;
                    end
                end
                S_READ:  r_state <= S_NOW;
                S_NOW:   r_state <= S_CMP;
                S_CMP: begin
                    r_lvl   <= '0;
                    r_state <= i_stat.first_word ? S_SCAN : S_WRITE;
                end
                S_SCAN: begin
                    if (r_lvl == LW'(LEVELS - 1)) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_lvl <= r_lvl + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.latch   = (r_state == S_IDLE) && i_start;
        o_cmd.rd      = (r_state == S_READ);
        o_cmd.calc    = (r_state == S_NOW);
        o_cmd.cmp     = (r_state == S_CMP);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.write   = (r_state == S_WRITE);
        o_cmd.clear   = (r_state == S_CLEAR);
        o_cmd.lvl     = r_lvl;
        o_cmd.clr_row = r_clr_row;
    end

    assign o_busy = r_busy;

endmodule

// ----- rtl/ddf_dpath.sv -----
// datapath: per-level slot memories, age and byte compares, victim scan
module ddf_dpath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ddf_pkg::t_cmd              i_cmd,
    output ddf_pkg::t_stat             o_stat,
    input  logic                       i_cfg_we,
    input  logic [ddf_pkg::WIN_W-1:0]  i_cfg_data,
    input  logic [31:0]                i_frame_hash,
    input  logic [15:0]                i_frame_length,
    input  logic [31:0]                i_seconds,
    input  logic [29:0]                i_nanoseconds,
    input  logic [63:0]                i_data_word,
    input  logic                       i_last_word,
    output logic                       o_result_valid,
    output logic                       o_is_duplicate
);
    import ddf_pkg::*;

    logic [WIN_W-1:0]  r_window;
    logic [RW-1:0]     r_row;
    logic [15:0]       r_len;
    logic [31:0]       r_sec;
    logic [29:0]       r_ns;
    logic [63:0]       r_data;
    logic              r_last;
    logic [61:0]       r_prod;
    logic [63:0]       r_now;
    logic [WPW-1:0]    r_wp;
    logic [LEVELS-1:0] r_still_eq;
    logic [LEVELS-1:0] r_mis;
    logic [LEVELS-1:0] r_empty;
    logic [63:0]       r_age [LEVELS];
    logic [63:0]       r_best;
    logic [LW-1:0]     r_victim;
    logic              r_out_valid;
    logic              r_dup;

    logic [63:0]       rd_stamp [LEVELS];
    logic [15:0]       rd_len   [LEVELS];
    logic [63:0]       rd_bytes [LEVELS];
    logic [63:0]       age_c    [LEVELS];
    logic [LEVELS-1:0] eq_c;
    logic [LEVELS-1:0] mis_c;
    logic [LEVELS-1:0] empty_c;
    logic [63:0]       mask;
    logic [BIDX_W-1:0] minim;
    logic [BIDX_W-1:0] base_idx;
    logic              in_range;
    logic [BAW-1:0]    byte_addr;
    logic [RW-1:0]     stamp_waddr;
    logic [LEVELS-1:0] mis_hit;

    assign minim    = (r_len < 16'(CHECK_BYTES)) ? BIDX_W'(r_len) : BIDX_W'(CHECK_BYTES);
    assign base_idx = BIDX_W'(r_wp) * BIDX_W'(8);
    assign in_range = (r_wp < WPW'(WORDS)) && (base_idx < minim);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            mask[b*8 +: 8] = {8{(base_idx + BIDX_W'(b)) < minim}};
        end
    end

    assign byte_addr   = BAW'(r_row) * BAW'(WORDS) + BAW'(r_wp);
    assign stamp_waddr = i_cmd.clear ? i_cmd.clr_row : r_row;
    assign mis_hit     = r_mis & {LEVELS{in_range}};

    for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
        ddf_ram #(.WIDTH(64), .DEPTH(TABLE_ROWS)) u_stamp (
            .i_clk   (i_clk),
            .i_we    (i_cmd.clear || (i_cmd.write && r_last && r_victim == LW'(l))),
            .i_waddr (stamp_waddr),
            .i_wdata (i_cmd.clear ? 64'd0 : r_now),
            .i_re    (i_cmd.rd),
            .i_raddr (r_row),
            .o_rdata (rd_stamp[l])
        );
        ddf_ram #(.WIDTH(16), .DEPTH(TABLE_ROWS)) u_len (
            .i_clk   (i_clk),
            .i_we    (i_cmd.write && r_last && r_victim == LW'(l)),
            .i_waddr (r_row),
            .i_wdata (r_len),
            .i_re    (i_cmd.rd),
            .i_raddr (r_row),
            .o_rdata (rd_len[l])
        );
        // merge keeps the stored bytes beyond the compared prefix
        ddf_ram #(.WIDTH(64), .DEPTH(TABLE_ROWS * WORDS)) u_bytes (
            .i_clk   (i_clk),
            .i_we    (i_cmd.write && in_range && r_victim == LW'(l)),
            .i_waddr (byte_addr),
            .i_wdata ((rd_bytes[l] & ~mask) | (r_data & mask)),
            .i_re    (i_cmd.rd),
            .i_raddr (byte_addr),
            .o_rdata (rd_bytes[l])
        );

        assign age_c[l]   = r_now - rd_stamp[l];
        assign empty_c[l] = (rd_stamp[l] == 64'd0);
        assign eq_c[l]    = !empty_c[l] && (age_c[l] <= {16'd0, r_window})
                            && (rd_len[l] == r_len);
        assign mis_c[l]   = (((rd_bytes[l] ^ r_data) & mask) != 64'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_row  <= i_frame_hash[RW-1:0];
            r_len  <= i_frame_length;
            r_sec  <= i_seconds;
            r_ns   <= i_nanoseconds;
            r_data <= i_data_word;
            r_last <= i_last_word;
        end
        if (i_cmd.rd) begin
            r_prod <= 62'(r_sec * NS_PER_SEC);
        end
        if (i_cmd.calc) begin
            r_now <= {2'b00, r_prod} + 64'(r_ns);
        end
        if (i_cmd.cmp) begin
            r_mis   <= mis_c;
            r_empty <= empty_c;
            for (int l = 0; l < LEVELS; l++) begin
                r_age[l] <= age_c[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RESET;
            r_wp        <= '0;
            r_still_eq  <= '0;
            r_victim    <= '0;
            r_best      <= '0;
            r_out_valid <= 1'b0;
            r_dup       <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.write && r_last;
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_cmd.cmp) begin
                r_best <= 64'd0;
            end
            if (i_cmd.cmp && o_stat.first_word) begin
                r_still_eq <= eq_c;
                r_victim   <= '0;
            end
            if (i_cmd.scan) begin
                if (r_empty[i_cmd.lvl]) begin
                    r_best   <= r_now;
                    r_victim <= i_cmd.lvl;
                end else if (r_age[i_cmd.lvl] > r_best) begin
                    r_best   <= r_age[i_cmd.lvl];
                    r_victim <= i_cmd.lvl;
                end
            end
            if (i_cmd.write) begin
                r_still_eq <= r_still_eq & ~mis_hit;
                r_dup      <= |(r_still_eq & ~mis_hit);
                if (r_last) begin
                    r_wp <= '0;
                end else if (r_wp < WPW'(WORDS)) begin
                    r_wp <= r_wp + 1'b1;
                end
            end
        end
    end

    assign o_stat.first_word = (r_wp == '0);
    assign o_result_valid    = r_out_valid;
    assign o_is_duplicate    = r_dup;

endmodule

// ----- rtl/duplicate_frame_filter_core.sv -----
// top level of the duplicate frame filter
// After reset the block clears its timestamp store, one row per cycle, and holds
// busy high while it does. Each accepted request (one data word) then keeps busy
// high through its steps, with a victim scan added only on the first word of a
// frame: memory read, timestamp multiply-add, age and byte compares, a victim scan
// of one level per cycle on first words, then the slot write. The verdict comes
// on o_is_duplicate with o_result_valid high for exactly one cycle after the
// last word of a frame; it is not held, so the receiver must take it then.
// Configuration writes are always ready and should be made while busy is low.
module duplicate_frame_filter_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [47:0] i_cfg_data,
    input  logic [31:0] i_frame_hash,
    input  logic [15:0] i_frame_length,
    input  logic [31:0] i_seconds,
    input  logic [29:0] i_nanoseconds,
    input  logic [63:0] i_data_word,
    input  logic        i_last_word,
    output logic        o_result_valid,
    output logic        o_is_duplicate
);
    import ddf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  ctrl_busy;

    assign o_cfg_ready = 1'b1;
    assign busy        = ctrl_busy;

    ddf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (ctrl_busy)
    );

    ddf_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_frame_hash   (i_frame_hash),
        .i_frame_length (i_frame_length),
        .i_seconds      (i_seconds),
        .i_nanoseconds  (i_nanoseconds),
        .i_data_word    (i_data_word),
        .i_last_word    (i_last_word),
        .o_result_valid (o_result_valid),
        .o_is_duplicate (o_is_duplicate)
    );

endmodule

// ----- rtl/ddf_checker.sv -----
// port-level checker for the duplicate frame filter and its bind
`include "duplicate_frame_filter_core_assert.svh"

module ddf_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);

    `DDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `DDF_ASSERT_NEXT(a_strobe_single, o_result_valid, !o_result_valid, "result strobe too long")
    `DDF_ASSERT_NOW(a_result_idle, o_result_valid, !busy, "result while still busy")
    `DDF_ASSERT_NOW(a_result_after_work, o_result_valid, $past(busy), "result without work")

endmodule

bind duplicate_frame_filter_core ddf_checker u_ddf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);

// ----- tb/tb_top.sv -----
// self-checking testbench for the duplicate frame filter core
`timescale 1ns / 100ps

module tb_top;
    import ddf_pkg::*;

    localparam int SLOT_COUNT = TABLE_ROWS * LEVELS;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;

    typedef struct {
        int unsigned row;
        logic [15:0] len;
        logic [31:0] sec;
        logic [29:0] ns;
        logic [63:0] data [WORDS];
    } frame_t;

    class dup_scoreboard;
        logic [WIN_W-1:0] window = WINDOW_RESET;
        bit [63:0] stamp_mem [SLOT_COUNT];
        bit [15:0] len_mem [SLOT_COUNT];
        bit [63:0] byte_mem [SLOT_COUNT * WORDS];
        int unsigned word_pos;
        bit [LEVELS-1:0] still_eq;
        int unsigned victim;
        bit verdicts [$];
        int failures;

        function void note_word(logic [31:0] hash, logic [15:0] len, logic [31:0] sec,
                                logic [29:0] ns, logic [63:0] data, logic last);
            int unsigned row, minim, nb, s, w;
            bit [63:0] now, best, age, mask;
            row = hash % TABLE_ROWS;
            now = {32'b0, sec} * NS_PER_SECOND + {34'b0, ns};
            minim = (len < CHECK_BYTES) ? len : CHECK_BYTES;
            if (word_pos == 0) begin
                best = 0;
                victim = 0;
                still_eq = '0;
                for (int l = 0; l < LEVELS; l++) begin
                    s = l * TABLE_ROWS + row;
                    if (stamp_mem[s] != 0) begin
                        age = now - stamp_mem[s];
                        if (age <= {16'b0, window} && len_mem[s] == len)
                            still_eq[l] = 1'b1;
                        if (age > best) begin
                            best = age;
                            victim = l;
                        end
                    end else begin
                        best = now;
                        victim = l;
                    end
                end
            end
            if (word_pos < WORDS && 8 * word_pos < minim) begin
                nb = minim - 8 * word_pos;
                mask = (nb >= 8) ? '1 : ((64'd1 << (8 * nb)) - 64'd1);
                for (int l = 0; l < LEVELS; l++) begin
                    w = (l * TABLE_ROWS + row) * WORDS + word_pos;
                    if (((byte_mem[w] ^ data) & mask) != 0)
                        still_eq[l] = 1'b0;
                end
                w = (victim * TABLE_ROWS + row) * WORDS + word_pos;
                byte_mem[w] = (byte_mem[w] & ~mask) | (data & mask);
            end
            if (last) begin
                s = victim * TABLE_ROWS + row;
                verdicts.push_back(still_eq != 0);
                stamp_mem[s] = now;
                len_mem[s] = len;
                word_pos = 0;
            end else if (word_pos < WORDS) begin
                word_pos++;
            end
        endfunction

        function void check_result(logic got);
            bit want;
            if (verdicts.size() == 0) begin
                $error("is_duplicate: unexpected result %0b", got);
                failures++;
            end else begin
                want = verdicts.pop_front();
                if (got !== want) begin
                    $error("is_duplicate: expected %0b, actual %0b", want, got);
                    failures++;
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [47:0] i_cfg_data;
    logic [31:0] i_frame_hash;
    logic [15:0] i_frame_length;
    logic [31:0] i_seconds;
    logic [29:0] i_nanoseconds;
    logic [63:0] i_data_word;
    logic        i_last_word;
    logic        o_result_valid;
    logic        o_is_duplicate;

    duplicate_frame_filter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_frame_hash   (i_frame_hash),
        .i_frame_length (i_frame_length),
        .i_seconds      (i_seconds),
        .i_nanoseconds  (i_nanoseconds),
        .i_data_word    (i_data_word),
        .i_last_word    (i_last_word),
        .o_result_valid (o_result_valid),
        .o_is_duplicate (o_is_duplicate)
    );

    dup_scoreboard sb = new();
    int unsigned pool_rows [8];
    frame_t recent [$];
    bit idle_on = 1'b1;
    int unsigned words_sent;
    logic [31:0] clock_sec = 32'd100;
    int stall_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side cannot stall, check every strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_is_duplicate);
    end

    always @(posedge i_clk) begin
        if (o_result_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_word(logic [31:0] hash, logic [15:0] len, logic [31:0] sec,
                             logic [29:0] ns, logic [63:0] data, logic last);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 33) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_frame_hash <= hash;
        i_frame_length <= len;
        i_seconds <= sec;
        i_nanoseconds <= ns;
        i_data_word <= data;
        i_last_word <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_word(hash, len, sec, ns, data, last);
        words_sent++;
    endtask

    // word count always covers the compared prefix; extra words are ignored by the block
    task automatic send_frame(frame_t f, int extra, bit jitter);
        int unsigned minim, nw, row;
        logic [31:0] hash, sec;
        logic [29:0] ns;
        logic [63:0] data;
        minim = (f.len < CHECK_BYTES) ? f.len : CHECK_BYTES;
        nw = (minim == 0) ? 1 : (minim + 7) / 8;
        nw += extra;
        for (int i = 0; i < nw; i++) begin
            row = f.row;
            sec = f.sec;
            ns = f.ns;
            if (jitter && $urandom_range(0, 3) == 0) begin
                row = pool_rows[$urandom_range(0, 7)];
                sec = $urandom();
                ns = 30'($urandom_range(0, 999999999));
            end
            hash = ($urandom() & ~(TABLE_ROWS - 1)) | row;
            data = (i < WORDS) ? f.data[i] : {$urandom(), $urandom()};
            send_word(hash, f.len, sec, ns, data, i == nw - 1);
        end
        recent.push_back(f);
        if (recent.size() > 64)
            void'(recent.pop_front());
    endtask

    function automatic frame_t fresh_frame();
        frame_t f;
        int pick;
        pick = $urandom_range(0, 99);
        f.row = pool_rows[$urandom_range(0, 7)];
        if (pick < 25)
            f.len = 16'($urandom_range(0, 8));
        else if (pick < 65)
            f.len = 16'($urandom_range(9, 64));
        else if (pick < 85)
            f.len = 16'($urandom_range(65, 200));
        else
            f.len = 16'($urandom());
        clock_sec += $urandom_range(0, 2);
        f.sec = ($urandom_range(0, 19) == 0) ? $urandom() : clock_sec;
        f.ns = 30'($urandom_range(0, 999999999));
        for (int i = 0; i < WORDS; i++)
            f.data[i] = {$urandom(), $urandom()};
        return f;
    endfunction

    // same frame seen again later, sometimes with one byte changed
    function automatic frame_t repeat_frame(frame_t f, int unsigned max_delay);
        logic [63:0] ns_sum;
        int unsigned pos;
        ns_sum = f.ns + $urandom_range(0, max_delay);
        f.sec = f.sec + 32'(ns_sum / NS_PER_SECOND);
        if ($urandom_range(0, 6) == 0)
            f.sec = f.sec + $urandom_range(1, 5);
        f.ns = 30'(ns_sum % NS_PER_SECOND);
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(0, WORDS * 8 - 1);
            f.data[pos / 8][8 * (pos % 8) +: 8] = ~f.data[pos / 8][8 * (pos % 8) +: 8];
        end
        return f;
    endfunction

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_window(logic [47:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.window = value;
    endtask

    task automatic random_phase(int unsigned word_count);
        int unsigned stop_at, pick;
        stop_at = words_sent + word_count;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 55 && recent.size() != 0)
                send_frame(repeat_frame(recent[$urandom_range(0, recent.size() - 1)],
                                        2500000), $urandom_range(0, 1), 1'b0);
            else if (pick < 90)
                send_frame(fresh_frame(), ($urandom_range(0, 4) == 0) ? 2 : 0, 1'b0);
            else
                send_frame(fresh_frame(), $urandom_range(0, 1), 1'b1);
        end
    endtask

    initial begin
        frame_t f, g;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_frame_hash = '0;
        i_frame_length = '0;
        i_seconds = '0;
        i_nanoseconds = '0;
        i_data_word = '0;
        i_last_word = 1'b0;
        pool_rows[0] = 0;
        pool_rows[1] = TABLE_ROWS - 1;
        for (int i = 2; i < 8; i++)
            pool_rows[i] = $urandom_range(1, TABLE_ROWS - 2);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        write_window(48'd1000000);

        // fill every level of the rows in use so compares only see written bytes
        // rising stamps make each fill frame take the highest empty level
        for (int r = 0; r < 8; r++) begin
            for (int l = 0; l < LEVELS; l++) begin
                f = fresh_frame();
                f.row = pool_rows[r];
                f.len = CHECK_BYTES;
                f.sec = clock_sec;
                f.ns = 30'(1000 * (r * LEVELS + l + 1));
                send_frame(f, 0, 1'b0);
            end
        end

        // directed: empty frame, one byte, longest frame at the clock limit, zero stamp
        f = fresh_frame();
        f.row = 0;
        f.len = 0;
        send_frame(f, 0, 1'b0);
        f.len = 1;
        for (int i = 0; i < WORDS; i++)
            f.data[i] = '1;
        send_frame(f, 0, 1'b0);
        f.ns = f.ns + 30'd1;
        send_frame(f, 0, 1'b0);
        f.row = TABLE_ROWS - 1;
        f.len = 16'hFFFF;
        f.sec = 32'hFFFF_FFFF;
        f.ns = 30'd999999999;
        for (int i = 0; i < WORDS; i++)
            f.data[i] = '0;
        send_word(32'hFFFF_FFFF, f.len, f.sec, f.ns, '0, 1'b0);
        send_frame(f, 1, 1'b0);
        g = f;
        g.row = pool_rows[2];
        g.len = 16'd12;
        g.sec = '0;
        g.ns = '0;
        send_frame(g, 0, 1'b0);
        g.data[1] = 64'hFFFF_FFFF_0000_0000;
        send_frame(g, 0, 1'b0);
        send_frame(repeat_frame(f, 10), 0, 1'b0);

        drain();
        random_phase(200);
        idle_on = 1'b0;
        random_phase(120);
        idle_on = 1'b1;
        drain();
        write_window('0);
        random_phase(120);
        drain();
        write_window('1);
        random_phase(150);
        drain();
        write_window({16'($urandom_range(0, 65535)), $urandom()});
        random_phase(120);
        drain();
        write_window(48'd2000000);
        random_phase(120);
        drain();

        if (sb.failures == 0 && sb.verdicts.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- duplicate_frame_filter_core.f -----
+incdir+rtl
rtl/ddf_pkg.sv
rtl/ddf_ram.sv
rtl/ddf_ctrl.sv
rtl/ddf_dpath.sv
rtl/duplicate_frame_filter_core.sv
rtl/ddf_checker.sv
tb/tb_top.sv
